@@ hdl/clww_pkg.sv @@
// Shared types, constants and the transaction builder for the LCD text writer.
// No dependencies; imported by clww_outq, the top level and the testbench.
package clww_pkg;

  // Word buffer geometry.
  localparam int WORD_DEPTH = 32;
  localparam int WORD_AW    = $clog2(WORD_DEPTH);
  localparam int HOLD_CAP   = 22;
  localparam int HOLD_LIMIT = (WORD_DEPTH < HOLD_CAP) ? WORD_DEPTH : HOLD_CAP;

  // Field widths.
  localparam int COL_W  = 6;
  localparam int LINE_W = 2;
  localparam int WL_W   = 6;
  localparam int BYTE_W = 8;

  localparam logic [WL_W-1:0] HOLD_LIM_W = WL_W'(HOLD_LIMIT);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_ONE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_TWO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_THREE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_FOUR  = 3'd4;

  // Register reset values.
  localparam logic [COL_W-1:0]  LINE_WIDTH_RST = 6'd20;
  localparam logic [BYTE_W-1:0] LINE_ONE_RST   = 8'h80;
  localparam logic [BYTE_W-1:0] LINE_TWO_RST   = 8'hC0;
  localparam logic [BYTE_W-1:0] LINE_THREE_RST = 8'h94;
  localparam logic [BYTE_W-1:0] LINE_FOUR_RST  = 8'hD4;

  // LCD codes.
  localparam logic [BYTE_W-1:0] LCD_CLEAR  = 8'h01;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;

  // Expander control bits: EN, backlight, RS.
  localparam logic [BYTE_W-1:0] NIB_MASK  = 8'hF0;
  localparam logic [BYTE_W-1:0] CMD_EN_HI = 8'h0C;
  localparam logic [BYTE_W-1:0] CMD_EN_LO = 8'h08;
  localparam logic [BYTE_W-1:0] DAT_EN_HI = 8'h0D;
  localparam logic [BYTE_W-1:0] DAT_EN_LO = 8'h09;

  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  // One LCD transaction as it goes to the expander.
  typedef struct packed {
    logic              reg_select;
    logic [BYTE_W-1:0] lcd_byte;
    logic [BYTE_W-1:0] bus_a;
    logic [BYTE_W-1:0] bus_b;
    logic [BYTE_W-1:0] bus_c;
    logic [BYTE_W-1:0] bus_d;
  } xact_t;

  // Request from the sequencer to the output queue.
  typedef struct packed {
    logic  push;   // new transaction
    logic  flush;  // item done: release the staged transaction as last
    xact_t xact;
  } emit_req_t;

  // Status of the output queue.
  typedef struct packed {
    logic ready;   // push or flush completes this cycle
    logic staged;  // a transaction waits in the staging register
  } oq_stat_t;

  function automatic xact_t mk_xact(input logic rs, input logic [BYTE_W-1:0] b);
    xact_t             x;
    logic [BYTE_W-1:0] hi;
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] on;
    logic [BYTE_W-1:0] off;
    hi = b & NIB_MASK;
    lo = {b[3:0], 4'h0};
    on  = rs ? DAT_EN_HI : CMD_EN_HI;
    off = rs ? DAT_EN_LO : CMD_EN_LO;
    x.reg_select = rs;
    x.lcd_byte   = b;
    x.bus_a      = hi | on;
    x.bus_b      = hi | off;
    x.bus_c      = lo | on;
    x.bus_d      = lo | off;
    return x;
  endfunction

endpackage

@@ hdl/clww_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module clww_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ hdl/clww_outq.sv @@
// Output queue: one staging register that delays each transaction until the
// next one (or the end of the item) is known, then the output register.
// Depends on clww_pkg.
module clww_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  clww_pkg::emit_req_t req_i,
  output clww_pkg::oq_stat_t  stat_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output clww_pkg::xact_t     out_xact_o,
  output logic                out_last_o
);
  import clww_pkg::*;

  logic  stg_v_q, stg_v_d;
  xact_t stg_q;
  logic  out_v_q, out_v_d;
  xact_t out_q;
  logic  last_q;
  logic  ready;
  logic  adv;

  // Ready when nothing is staged, or the output register is empty or draining this cycle.
  assign ready = !stg_v_q || !out_v_q || !out_stall_i;
  assign adv   = (req_i.push || req_i.flush) && ready && stg_v_q;

  always_comb begin
    stg_v_d = stg_v_q;
    if (ready && req_i.push) begin
      stg_v_d = 1'b1;
    end else if (ready && req_i.flush) begin
      stg_v_d = 1'b0;
    end
    if (adv) begin
      out_v_d = 1'b1;
    end else begin
      out_v_d = out_v_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      stg_v_q <= stg_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && req_i.push) begin
      stg_q <= req_i.xact;
    end
    if (adv) begin
      out_q  <= stg_q;
      last_q <= req_i.flush;
    end
  end

  assign stat_o.ready  = ready;
  assign stat_o.staged = stg_v_q;
  assign out_valid_o   = out_v_q;
  assign out_xact_o    = out_q;
  assign out_last_o    = last_q;

endmodule

@@ hdl/char_lcd_word_wrap_writer_core.sv @@
// Top level of the word-wrapping character LCD writer: configuration
// registers, the transaction sequencer and the word store.
// Depends on clww_pkg, clww_ram and clww_outq.

// Takes one string character per transfer and produces the LCD transactions
// it causes, one result per transaction, each carrying the command or data
// byte and the four I2C expander bytes (high and low nibble, EN strobed,
// backlight on, RS set for data); last_of_run_o marks the final transaction
// of an item, and an item may cause none. A first character sends a clear
// and homes to line one. A space or newline away from column zero is held
// while the next word is collected in the word store; once the word is
// complete, or grows to the room left on the line (capped at 22 characters),
// the block either advances to the next line and drops the delimiter, or
// writes the delimiter, and then replays the word. Reaching the line width
// always wraps; lines cycle through the four address commands.
// Timing: one item is in flight at a time. The word store read is registered
// and the sequencer emits at most one transaction per cycle, fewer while the
// output stalls. A new line width is sampled only when an item is accepted
// with no word held; the line address registers are read as they stand, so
// a write to them also reaches an item in flight.
module char_lcd_word_wrap_writer_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // character input
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [clww_pkg::BYTE_W-1:0]        char_code_i,
  input  logic                               first_char_i,
  input  logic                               end_of_string_i,
  // transaction output
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               reg_select_o,
  output logic [clww_pkg::BYTE_W-1:0]        lcd_byte_o,
  output logic [clww_pkg::BYTE_W-1:0]        bus_byte_a_o,
  output logic [clww_pkg::BYTE_W-1:0]        bus_byte_b_o,
  output logic [clww_pkg::BYTE_W-1:0]        bus_byte_c_o,
  output logic [clww_pkg::BYTE_W-1:0]        bus_byte_d_o,
  output logic                               last_of_run_o,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [clww_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [clww_pkg::BYTE_W-1:0]        cfg_data_i
);
  import clww_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_CLEAR    = 9'b000000010,
    ST_DISPATCH = 9'b000000100,
    ST_PUT      = 9'b000001000,
    ST_R_HEAD   = 9'b000010000,
    ST_R_CHAR   = 9'b000100000,
    ST_R_END    = 9'b001000000,
    ST_WRAP     = 9'b010000000,
    ST_FINISH   = 9'b100000000
  } state_e;

  // Configuration registers.
  logic [COL_W-1:0]  line_width_q;
  logic [BYTE_W-1:0] line_one_q, line_two_q, line_three_q, line_four_q;

  // Sequencer state.
  state_e            state_q, state_d;
  state_e            after_q, after_d;     // where to go once a wrap is sent
  logic [COL_W-1:0]  col_q, col_d;
  logic [LINE_W-1:0] line_q, line_d;
  logic [WL_W-1:0]   wl_q, wl_d;
  logic [WL_W-1:0]   idx_q, idx_d;
  logic              pend_q, pend_d;
  logic [BYTE_W-1:0] held_q, held_d;
  logic [COL_W-1:0]  wid_q, wid_d;
  logic              again_q, again_d;     // decide the new delimiter after a replay

  // Current item.
  logic [BYTE_W-1:0] code_q;
  logic              eos_q;
  logic              delim_q;

  // Word store port.
  logic              ram_we;
  logic              ram_re;
  logic [WORD_AW-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  // Output queue.
  emit_req_t         req;
  oq_stat_t          oq_stat;
  xact_t             out_xact;

  // Helpers.
  logic              in_acc;
  logic              in_delim;
  logic              pend_eff;
  logic [LINE_W-1:0] line_inc;
  logic [BYTE_W-1:0] line_cmd;
  logic [COL_W-1:0]  col_inc;
  logic              col_wrap;
  logic [COL_W-1:0]  room;
  logic [WL_W-1:0]   thr;
  logic              head_break;
  logic [WL_W-1:0]   idx_inc;
  logic              more;
  logic              has_word;
  state_e            word_next;

  // ------------------------------------------------------------------
  // Configuration port
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LINE_WIDTH_RST;
      line_one_q   <= LINE_ONE_RST;
      line_two_q   <= LINE_TWO_RST;
      line_three_q <= LINE_THREE_RST;
      line_four_q  <= LINE_FOUR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LINE_WIDTH: line_width_q <= cfg_data_i[COL_W-1:0];
        CFG_LINE_ONE:   line_one_q   <= cfg_data_i;
        CFG_LINE_TWO:   line_two_q   <= cfg_data_i;
        CFG_LINE_THREE: line_three_q <= cfg_data_i;
        CFG_LINE_FOUR:  line_four_q  <= cfg_data_i;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Datapath helpers
  // ------------------------------------------------------------------
  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign in_delim = (char_code_i == CH_SPACE) || (char_code_i == CH_NEWLINE);
  // first_char discards whatever word was held
  assign pend_eff = pend_q && !first_char_i;

  assign line_inc = line_q + LINE_W'(1);
  always_comb begin
    case (line_inc)
      2'd1:    line_cmd = line_two_q;
      2'd2:    line_cmd = line_three_q;
      2'd3:    line_cmd = line_four_q;
      default: line_cmd = line_one_q;
    endcase
  end

  assign col_inc  = col_q + COL_W'(1);
  assign col_wrap = col_inc >= wid_q;

  // Room left on the line, capped by the word store hold limit.
  assign room = (wid_q > col_q) ? (wid_q - col_q) : '0;
  assign thr  = (WL_W'(room) < HOLD_LIM_W) ? WL_W'(room) : HOLD_LIM_W;

  // The held word does not fit: advance the line and drop the delimiter.
  assign head_break = (col_q != '0) &&
                      (({1'b0, col_q} + {1'b0, wl_q}) >= {1'b0, wid_q});

  assign idx_inc   = idx_q + WL_W'(1);
  assign more      = idx_inc < wl_q;
  assign has_word  = wl_q != '0;
  assign word_next = has_word ? ST_R_CHAR : ST_R_END;

  // ------------------------------------------------------------------
  // Sequencer
  // ------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    after_d   = after_q;
    col_d     = col_q;
    line_d    = line_q;
    wl_d      = wl_q;
    idx_d     = idx_q;
    pend_d    = pend_q;
    held_d    = held_q;
    wid_d     = wid_q;
    again_d   = again_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    req.push  = 1'b0;
    req.flush = 1'b0;
    req.xact  = mk_xact(RS_CMD, line_cmd);

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (first_char_i) begin
            col_d  = '0;
            line_d = '0;
            wl_d   = '0;
            pend_d = 1'b0;
          end
          // width is sampled only while no word is held
          if (!pend_eff) begin
            wid_d = (line_width_q == '0) ? COL_W'(1) : line_width_q;
          end
          // a word character: append it to the store
          if (pend_eff && !in_delim) begin
            ram_we = 1'b1;
            wl_d   = wl_q + WL_W'(1);
          end
          again_d = 1'b0;
          state_d = first_char_i ? ST_CLEAR : ST_DISPATCH;
        end
      end

      ST_CLEAR: begin
        req.push = 1'b1;
        req.xact = mk_xact(RS_CMD, LCD_CLEAR);
        if (oq_stat.ready) begin
          state_d = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        idx_d = '0;
        if (pend_q) begin
          if (delim_q) begin
            // new delimiter ends the word: replay, then hold this one
            again_d = 1'b1;
            state_d = ST_R_HEAD;
          end else if (eos_q || (wl_q >= thr)) begin
            state_d = ST_R_HEAD;
          end else begin
            state_d = ST_FINISH;
          end
        end else if (delim_q) begin
          pend_d = 1'b1;
          held_d = code_q;
          wl_d   = '0;
          if ((col_q == '0) || eos_q || (thr == '0)) begin
            state_d = ST_R_HEAD;
          end else begin
            state_d = ST_FINISH;
          end
        end else begin
          state_d = ST_PUT;
        end
      end

      ST_PUT: begin
        req.push = 1'b1;
        req.xact = mk_xact(RS_DATA, code_q);
        if (oq_stat.ready) begin
          col_d   = col_inc;
          after_d = ST_FINISH;
          state_d = col_wrap ? ST_WRAP : ST_FINISH;
        end
      end

      ST_R_HEAD: begin
        req.push = 1'b1;
        if (head_break) begin
          req.xact = mk_xact(RS_CMD, line_cmd);
        end else begin
          req.xact = mk_xact(RS_DATA, held_q);
        end
        if (oq_stat.ready) begin
          // fetch the first word character while the head goes out
          ram_re    = has_word;
          ram_raddr = '0;
          if (head_break) begin
            line_d  = line_inc;
            col_d   = '0;
            state_d = word_next;
          end else begin
            col_d   = col_inc;
            after_d = word_next;
            state_d = col_wrap ? ST_WRAP : word_next;
          end
        end
      end

      ST_R_CHAR: begin
        req.push = 1'b1;
        req.xact = mk_xact(RS_DATA, ram_rdata);
        if (oq_stat.ready) begin
          ram_re    = more;
          ram_raddr = idx_inc[WORD_AW-1:0];
          idx_d     = idx_inc;
          col_d     = col_inc;
          after_d   = more ? ST_R_CHAR : ST_R_END;
          if (col_wrap) begin
            state_d = ST_WRAP;
          end else begin
            state_d = more ? ST_R_CHAR : ST_R_END;
          end
        end
      end

      ST_R_END: begin
        pend_d  = 1'b0;
        wl_d    = '0;
        again_d = 1'b0;
        state_d = again_q ? ST_DISPATCH : ST_FINISH;
      end

      ST_WRAP: begin
        req.push = 1'b1;
        req.xact = mk_xact(RS_CMD, line_cmd);
        if (oq_stat.ready) begin
          line_d  = line_inc;
          col_d   = '0;
          state_d = after_q;
        end
      end

      ST_FINISH: begin
        // release the staged transaction marked as last
        req.flush = oq_stat.staged;
        if (oq_stat.ready) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      after_q <= ST_FINISH;
      col_q   <= '0;
      line_q  <= '0;
      wl_q    <= '0;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      held_q  <= '0;
      wid_q   <= LINE_WIDTH_RST;
      again_q <= 1'b0;
    end else begin
      state_q <= state_d;
      after_q <= after_d;
      col_q   <= col_d;
      line_q  <= line_d;
      wl_q    <= wl_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      held_q  <= held_d;
      wid_q   <= wid_d;
      again_q <= again_d;
    end
  end

  // Hold the accepted item for the sequencer.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      code_q  <= char_code_i;
      eos_q   <= end_of_string_i;
      delim_q <= in_delim;
    end
  end

  assign in_stall_o = state_q != ST_IDLE;

  // ------------------------------------------------------------------
  // Word store and output queue
  // ------------------------------------------------------------------
  clww_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (WORD_DEPTH)
  ) u_word_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wl_q[WORD_AW-1:0]),
    .wdata_i (char_code_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  clww_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .stat_o      (oq_stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_xact_o  (out_xact),
    .out_last_o  (last_of_run_o)
  );

  assign reg_select_o = out_xact.reg_select;
  assign lcd_byte_o   = out_xact.lcd_byte;
  assign bus_byte_a_o = out_xact.bus_a;
  assign bus_byte_b_o = out_xact.bus_b;
  assign bus_byte_c_o = out_xact.bus_c;
  assign bus_byte_d_o = out_xact.bus_d;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  // Each item leaves nothing staged behind: its last transaction is out.
  a_stage_flushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !oq_stat.staged)
    else $error("transaction left staged at item transfer");

  // A held delimiter sits away from column zero with a word below the limit.
  a_hold_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && pend_q) |-> (col_q != '0 && wl_q < HOLD_LIM_W))
    else $error("inconsistent held word state");

  // Replay never reads past the collected word.
  a_read_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_R_CHAR) |-> (idx_q < wl_q))
    else $error("word store read beyond word length");

endmodule

@@ test/char_lcd_word_wrap_writer_core_tb.sv @@
// Self-checking testbench for char_lcd_word_wrap_writer_core: directed strings, then random text
// under random input gaps and output stalls, checked against an in-bench word-wrap predictor.
// Depends on clww_pkg and the RTL of the block; reads no files.
module char_lcd_word_wrap_writer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import clww_pkg::*;

  localparam int ITEM_GOAL      = 460;   // total characters to send
  localparam int MAX_XFERS      = 26;    // most transactions one character can cause
  localparam int SETTLE_CYCLES  = 40;    // latency margin once nothing is expected
  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transfer
  localparam int REPORT_LIMIT   = 10;

  localparam logic [CFG_IDX_W-1:0] LINE_REGS [4] =
    '{CFG_LINE_ONE, CFG_LINE_TWO, CFG_LINE_THREE, CFG_LINE_FOUR};

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_e;

  // One LCD transaction as seen on the result port.
  typedef struct packed {
    logic              rs;
    logic [BYTE_W-1:0] lcd;
    logic [BYTE_W-1:0] bus_a;
    logic [BYTE_W-1:0] bus_b;
    logic [BYTE_W-1:0] bus_c;
    logic [BYTE_W-1:0] bus_d;
    logic              end_mark;
  } lcd_xfer_t;

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              in_valid      = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] char_code     = '0;
  logic              first_char    = 1'b0;
  logic              end_of_string = 1'b0;
  logic              out_valid;
  logic              out_stall     = 1'b0;
  logic              reg_select;
  logic [BYTE_W-1:0] lcd_byte;
  logic [BYTE_W-1:0] bus_a, bus_b, bus_c, bus_d;
  logic              last_of_run;
  logic              cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx    = '0;
  logic [BYTE_W-1:0] cfg_data      = '0;

  char_lcd_word_wrap_writer_core u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .char_code_i     (char_code),
    .first_char_i    (first_char),
    .end_of_string_i (end_of_string),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .reg_select_o    (reg_select),
    .lcd_byte_o      (lcd_byte),
    .bus_byte_a_o    (bus_a),
    .bus_byte_b_o    (bus_b),
    .bus_byte_c_o    (bus_c),
    .bus_byte_d_o    (bus_d),
    .last_of_run_o   (last_of_run),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Wrap predictor: display position, held word and register copies.
  // ---------------------------------------------------------------------------
  logic [5:0]        cfg_width = LINE_WIDTH_RST;
  logic [BYTE_W-1:0] line_cmd [4] = '{LINE_ONE_RST, LINE_TWO_RST, LINE_THREE_RST, LINE_FOUR_RST};
  logic [5:0]        wrap_width = LINE_WIDTH_RST;  // width latched while no word is held
  logic [5:0]        cur_col    = '0;
  logic [1:0]        cur_line   = '0;
  logic [5:0]        held_len   = '0;
  logic              held_flag  = 1'b0;
  logic [BYTE_W-1:0] held_delim = '0;
  logic [BYTE_W-1:0] word_buf [WORD_DEPTH];

  lcd_xfer_t item_xfers [$];     // transactions of the character being predicted
  lcd_xfer_t lcd_expect_q [$];   // transactions still owed by the block

  int err_count   = 0;
  int items_sent  = 0;
  int burst_left  = 1;
  int idle_cycles = 0;

  function automatic void queue_xfer(input logic rs, input logic [BYTE_W-1:0] b);
    lcd_xfer_t         x;
    logic [BYTE_W-1:0] en_hi;
    logic [BYTE_W-1:0] en_lo;
    if (item_xfers.size() >= MAX_XFERS) return;
    en_hi      = rs ? DAT_EN_HI : CMD_EN_HI;
    en_lo      = rs ? DAT_EN_LO : CMD_EN_LO;
    x.rs       = rs;
    x.lcd      = b;
    x.bus_a    = {b[7:4], 4'h0} | en_hi;
    x.bus_b    = {b[7:4], 4'h0} | en_lo;
    x.bus_c    = {b[3:0], 4'h0} | en_hi;
    x.bus_d    = {b[3:0], 4'h0} | en_lo;
    x.end_mark = 1'b0;
    item_xfers.push_back(x);
  endfunction

  function automatic void advance_line();
    cur_line = cur_line + 2'd1;
    cur_col  = '0;
    queue_xfer(RS_CMD, line_cmd[cur_line]);
  endfunction

  function automatic void write_char(input logic [BYTE_W-1:0] ch);
    queue_xfer(RS_DATA, ch);
    cur_col = cur_col + 6'd1;
    if (cur_col >= wrap_width) advance_line();
  endfunction

  // Room for a held word, capped at the hold limit.
  function automatic int hold_room();
    int room;
    room = (wrap_width > cur_col) ? int'(wrap_width) - int'(cur_col) : 0;
    return (room < HOLD_LIMIT) ? room : HOLD_LIMIT;
  endfunction

  // Decide the held delimiter: drop it and take a new line if the word cannot
  // fit, else write it; then replay the word.
  function automatic void flush_word();
    if (cur_col != 0 && int'(cur_col) + int'(held_len) >= int'(wrap_width))
      advance_line();
    else
      write_char(held_delim);
    for (int i = 0; i < int'(held_len) && i < WORD_DEPTH; i++) write_char(word_buf[i]);
    held_flag = 1'b0;
    held_len  = '0;
  endfunction

  function automatic void predict_char(input logic [BYTE_W-1:0] code, input logic is_first,
                                       input logic is_eos);
    logic is_delim;
    logic taken;
    is_delim = (code == CH_SPACE) || (code == CH_NEWLINE);
    taken    = 1'b0;
    item_xfers.delete();
    if (is_first) begin
      cur_col   = '0;
      cur_line  = '0;
      held_len  = '0;
      held_flag = 1'b0;
      queue_xfer(RS_CMD, LCD_CLEAR);
    end
    if (!held_flag) wrap_width = (cfg_width != 0) ? cfg_width : 6'd1;
    if (held_flag) begin
      if (is_delim) begin
        flush_word();
      end else begin
        if (held_len < WORD_DEPTH) word_buf[held_len] = code;
        held_len = held_len + 6'd1;
        if (is_eos || int'(held_len) >= hold_room()) flush_word();
        taken = 1'b1;
      end
    end
    if (!taken) begin
      if (is_delim) begin
        held_flag  = 1'b1;
        held_delim = code;
        held_len   = '0;
        // nothing to wait for at column zero, at end of string or on a full line
        if (cur_col == 0 || is_eos || hold_room() == 0) flush_word();
      end else begin
        write_char(code);
      end
    end
    if (item_xfers.size() > 0) item_xfers[item_xfers.size()-1].end_mark = 1'b1;
    foreach (item_xfers[i]) lcd_expect_q.push_back(item_xfers[i]);
  endfunction

  function automatic void log_error(input string msg);
    err_count++;
    if (err_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic string xfer_text(input lcd_xfer_t x);
    return $sformatf("rs=%0d byte=%02h a=%02h b=%02h c=%02h d=%02h last=%0d",
                     x.rs, x.lcd, x.bus_a, x.bus_b, x.bus_c, x.bus_d, x.end_mark);
  endfunction

  // ---------------------------------------------------------------------------
  // Transfer monitor: predict on each accepted character, check each accepted
  // transaction against the oldest one owed. All sampling happens at the edge,
  // before any of this step's nonblocking updates land.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    lcd_xfer_t got;
    lcd_xfer_t want;
    if (rst_n && in_valid && !in_stall) predict_char(char_code, first_char, end_of_string);
    if (rst_n && out_valid && !out_stall) begin
      got = '{reg_select, lcd_byte, bus_a, bus_b, bus_c, bus_d, last_of_run};
      if (lcd_expect_q.size() == 0) begin
        log_error({"unexpected transaction: ", xfer_text(got)});
      end else begin
        want = lcd_expect_q.pop_front();
        if (got.rs !== want.rs || got.lcd !== want.lcd || got.bus_a !== want.bus_a ||
            got.bus_b !== want.bus_b || got.bus_c !== want.bus_c ||
            got.bus_d !== want.bus_d || got.end_mark !== want.end_mark)
          log_error({"mismatch: expected ", xfer_text(want), " got ", xfer_text(got)});
      end
    end
  end

  // Watchdog: any transfer on either side restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("char_lcd_word_wrap_writer_core_tb: errors");
      $finish;
    end
  end

  // Receiver stall: switch at random between stall styles after runs of random length,
  // including stretches with no stall at all.
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_run  = 50;
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_run  = $urandom_range(30, 200);
    end else begin
      stall_run--;
    end
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
      default:      out_stall <= ~out_stall;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------

  // Send one character and hold it until the transfer. Valid stays high when
  // the burst goes on, so the caller must send the next one in the same step.
  task automatic send_char(input logic [BYTE_W-1:0] code, input logic is_first,
                           input logic is_eos);
    in_valid      <= 1'b1;
    char_code     <= code;
    first_char    <= is_first;
    end_of_string <= is_eos;
    do @(posedge clk); while (in_stall);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
  endtask

  // Drop valid, let every owed transaction drain, then allow for an item
  // that produces nothing but may still be in flight.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (lcd_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_LINE_WIDTH: cfg_width   = data[5:0];
      CFG_LINE_ONE:   line_cmd[0] = data;
      CFG_LINE_TWO:   line_cmd[1] = data;
      CFG_LINE_THREE: line_cmd[2] = data;
      CFG_LINE_FOUR:  line_cmd[3] = data;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: clear, delimiters at column zero, held newline,
  // restart mid-word, byte extremes, delimiter carrying end of string.
  task automatic test_clear_and_delimiters();
    send_char(CH_SPACE,   1'b1, 1'b0);  // written at once, column zero
    send_char(8'h41,      1'b0, 1'b0);
    send_char(CH_NEWLINE, 1'b0, 1'b0);  // held
    send_char(8'h42,      1'b0, 1'b0);  // buffered, nothing out
    send_char(8'h43,      1'b1, 1'b0);  // new string drops the held word
    send_char(8'hFF,      1'b0, 1'b0);
    send_char(8'h00,      1'b0, 1'b0);
    send_char(CH_SPACE,   1'b0, 1'b0);  // held
    send_char(CH_SPACE,   1'b0, 1'b1);  // flush empty word, then decide this one
    wait_idle();
  endtask

  // Narrow line with all four address commands set, extremes among them:
  // hard wrap on a full line and a word that cannot fit.
  task automatic test_narrow_hard_wrap();
    write_reg(CFG_LINE_WIDTH, 8'd4);
    write_reg(CFG_LINE_ONE,   8'h00);
    write_reg(CFG_LINE_TWO,   8'hFF);
    write_reg(CFG_LINE_THREE, 8'h5A);
    write_reg(CFG_LINE_FOUR,  8'hA5);
    send_char(8'h70, 1'b1, 1'b0);
    send_char(8'h71, 1'b0, 1'b0);
    send_char(8'h72, 1'b0, 1'b0);
    send_char(8'h73, 1'b0, 1'b0);       // line full, wraps
    send_char(8'h74, 1'b0, 1'b0);
    send_char(CH_SPACE, 1'b0, 1'b0);    // held with room for three
    send_char(8'h75, 1'b0, 1'b0);
    send_char(8'h76, 1'b0, 1'b0);
    send_char(8'h77, 1'b0, 1'b0);       // reaches the room: new line, delimiter dropped
    send_char(CH_NEWLINE, 1'b0, 1'b1);
    wait_idle();
  endtask

  // Width written while a word is held: the old width judges that word, the
  // new one applies afterwards and wraps a column already past it.
  task automatic test_width_change_mid_word();
    write_reg(CFG_LINE_WIDTH, 8'd10);
    send_char(8'h61, 1'b1, 1'b0);
    send_char(8'h62, 1'b0, 1'b0);
    send_char(CH_SPACE, 1'b0, 1'b0);
    send_char(8'h63, 1'b0, 1'b0);
    wait_idle();
    write_reg(CFG_LINE_WIDTH, 8'd3);
    send_char(8'h64, 1'b0, 1'b0);
    send_char(8'h65, 1'b0, 1'b1);       // end of string flushes the word
    send_char(8'h66, 1'b0, 1'b0);       // column past the new width: wrap after it
    wait_idle();
  endtask

  function automatic logic [BYTE_W-1:0] pick_letter();
    if ($urandom_range(0, 7) == 0) return BYTE_W'($urandom_range(0, 255));
    return BYTE_W'($urandom_range(8'h21, 8'h7E));
  endfunction

  function automatic logic [BYTE_W-1:0] pick_cmd();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Random strings of words under changing settings. Mostly well-formed text,
  // with stray restarts, early end marks, doubled delimiters and raw bytes.
  task automatic test_random_text();
    logic [BYTE_W-1:0] text [$];
    int                phase;
    int                n_words;
    int                word_len;
    int                width;
    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      wait_idle();
      case (phase)
        0:       width = 40;
        1:       width = 1;
        2:       width = 2;
        default: width = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 40 : 1)
                                                     : $urandom_range(1, 40);
      endcase
      write_reg(CFG_LINE_WIDTH, BYTE_W'(width));
      foreach (LINE_REGS[r]) if ($urandom_range(0, 1)) write_reg(LINE_REGS[r], pick_cmd());
      repeat ($urandom_range(2, 5)) begin
        text.delete();
        n_words = $urandom_range(1, 8);
        for (int w = 0; w < n_words; w++) begin
          // now and then a word of 20 to 30 characters, around and past the hold limit
          word_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 30) : $urandom_range(1, 7);
          for (int k = 0; k < word_len; k++) text.push_back(pick_letter());
          if (w != n_words - 1 || $urandom_range(0, 3) == 0) begin
            text.push_back($urandom_range(0, 1) ? CH_SPACE : CH_NEWLINE);
            if ($urandom_range(0, 7) == 0) text.push_back(CH_SPACE);
          end
        end
        for (int k = 0; k < text.size(); k++)
          send_char(text[k], (k == 0) || ($urandom_range(0, 59) == 0),
                    (k == text.size() - 1) || ($urandom_range(0, 59) == 0));
      end
      phase++;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_clear_and_delimiters();
    test_narrow_hard_wrap();
    test_width_change_mid_word();
    test_random_text();
    wait_idle();
    if (err_count == 0 && lcd_expect_q.size() == 0)
      $display("char_lcd_word_wrap_writer_core_tb: clean");
    else
      $display("char_lcd_word_wrap_writer_core_tb: errors");
    $finish;
  end

endmodule
